// File: src/sattt_pkg.sv
// shared types, constants and entry packing for the set-associative table
package sattt_pkg;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 6;
  localparam int SCORE_W = 16;
  localparam int MOVE_W  = 16;
  localparam int BOUND_W = 2;
  localparam int INFO_W  = 46;
  localparam int ENTRY_W = KEY_W + INFO_W;

  // info word layout
  localparam int DEPTH_LSB = 0;
  localparam int LIMIT_LSB = 6;
  localparam int SCORE_LSB = 12;
  localparam int MOVE_LSB  = 28;
  localparam int BOUND_LSB = 44;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // one operation word as held inside the block
  typedef struct packed {
    kind_t               kind;
    logic [KEY_W-1:0]    key;
    logic [DEPTH_W-1:0]  depth;
    logic [DEPTH_W-1:0]  limit;
    logic [SCORE_W-1:0]  score;
    logic [MOVE_W-1:0]   mv;
    logic [BOUND_W-1:0]  bound;
  } req_t;

  // outcome of one bucket update
  typedef struct packed {
    logic                wr;
    logic                hit;
    logic [INFO_W-1:0]   info;
  } upd_res_t;

  function automatic logic [INFO_W-1:0] pack_info(input req_t r);
    return {r.bound, r.mv, r.score, r.limit, r.depth};
  endfunction

endpackage

// File: src/set_assoc_transposition_table_core.sv
// set-associative transposition table: top level with bucket row memory
//
//  channel | ports                                   | direction
//  in_     | valid, ready, kind, key, depth .. bound | word into the block
//  out_    | valid, ready, hit, found_*              | lookup result word
//
// a word is accepted with its row read, then updated and written back
// when BUCKETS is a power of two; otherwise the bucket index comes from a
// byte fold, a reciprocal multiply and a correction step that issues the row
// read, before the update and write back. clear, and reset, run a pass over
// all BUCKETS rows with in_ready low. a lookup whose result cannot leave
// waits in update.
module set_assoc_transposition_table_core import sattt_pkg::*; #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [DEPTH_W-1:0]  in_search_depth,
  input  logic [DEPTH_W-1:0]  in_iteration_limit,
  input  logic signed [SCORE_W-1:0] in_score_value,
  input  logic [MOVE_W-1:0]   in_best_move,
  input  logic [BOUND_W-1:0]  in_bound_kind,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic [DEPTH_W-1:0]  out_found_depth,
  output logic [DEPTH_W-1:0]  out_found_limit,
  output logic signed [SCORE_W-1:0] out_found_score,
  output logic [MOVE_W-1:0]   out_found_move,
  output logic [BOUND_W-1:0]  out_found_bound
);

  // weight of key byte i modulo BUCKETS
  function automatic logic [31:0] fold_c(input int i);
    return 32'((64'd1 << (8 * i)) % 64'(BUCKETS));
  endfunction

  localparam int BW      = $clog2(BUCKETS);
  localparam int FW      = $clog2(WAYS + 1);
  localparam int RW      = FW + WAYS * ENTRY_W;
  localparam bit IS_POW2 = (BUCKETS == (1 << BW));
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [31:0] FOLD_C [8] = '{fold_c(0), fold_c(1), fold_c(2), fold_c(3),
                                         fold_c(4), fold_c(5), fold_c(6), fold_c(7)};

  typedef enum logic [2:0] {
    ST_IDLE, ST_FOLD, ST_RECIP, ST_REDUCE, ST_EVAL, ST_CLEAR
  } state_t;

  state_t         state_r;
  req_t           req_r;
  logic [BW-1:0]  bidx_r;
  logic [BW-1:0]  clr_r;
  logic [31:0]    fold_r;
  logic [31:0]    q_r;
  logic           out_valid_r;
  upd_res_t       out_r;

  logic [RW-1:0]  mem [BUCKETS];
  logic [RW-1:0]  rd_q;
  logic           rd_en;
  logic [BW-1:0]  rd_addr;
  logic           we;
  logic [BW-1:0]  wa;
  logic [RW-1:0]  wd;

  logic [RW-1:0]  row_new;
  upd_res_t       upd;
  logic [31:0]    fold_sum;
  logic [63:0]    q_prod;
  logic [31:0]    rem_full;
  logic [31:0]    rem_val;
  logic           accept;
  logic           eval_done;
  req_t           in_req;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_hit         = out_r.hit;
  assign out_found_depth = out_r.info[DEPTH_LSB +: DEPTH_W];
  assign out_found_limit = out_r.info[LIMIT_LSB +: DEPTH_W];
  assign out_found_score = out_r.info[SCORE_LSB +: SCORE_W];
  assign out_found_move  = out_r.info[MOVE_LSB +: MOVE_W];
  assign out_found_bound = out_r.info[BOUND_LSB +: BOUND_W];

  assign in_req = '{kind: kind_t'(in_kind), key: in_key, depth: in_search_depth,
                    limit: in_iteration_limit, score: in_score_value,
                    mv: in_best_move, bound: in_bound_kind};

  sattt_update #(.WAYS(WAYS)) u_update (
    .req   (req_r),
    .row_i (rd_q),
    .row_o (row_new),
    .res   (upd)
  );

  // key mod BUCKETS: byte fold, reciprocal quotient estimate, one correction
  always_comb begin
    fold_sum = '0;
    for (int i = 0; i < 8; i++) begin
      fold_sum = fold_sum + 32'(req_r.key[8*i +: 8]) * FOLD_C[i];
    end
    q_prod   = 64'(fold_r) * 64'(RECIP);
    rem_full = fold_r - q_r * 32'(BUCKETS);
    rem_val  = (rem_full >= 32'(BUCKETS)) ? rem_full - 32'(BUCKETS) : rem_full;
  end

  // update can finish unless a lookup result has nowhere to go
  assign eval_done = (state_r == ST_EVAL) &&
                     !((req_r.kind == KIND_LOOKUP) && out_valid_r && !out_ready);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_key[BW-1:0];
    if (state_r == ST_IDLE && accept && IS_POW2 &&
        (in_kind == KIND_STORE || in_kind == KIND_LOOKUP)) begin
      rd_en = 1'b1;
    end else if (state_r == ST_REDUCE) begin
      rd_en   = 1'b1;
      rd_addr = rem_val[BW-1:0];
    end
    we = 1'b0;
    wa = bidx_r;
    wd = row_new;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
      wa = clr_r;
      wd = '0;
    end else if (eval_done) begin
      we = upd.wr;
    end
  end

  // bucket row memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (eval_done && req_r.kind == KIND_LOOKUP) begin
        out_valid_r <= 1'b1;
        out_r       <= upd;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rd_en) begin
        bidx_r <= rd_addr;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            req_r <= in_req;
            case (in_kind)
              KIND_STORE, KIND_LOOKUP: state_r <= IS_POW2 ? ST_EVAL : ST_FOLD;
              KIND_CLEAR: begin
                clr_r   <= '0;
                state_r <= ST_CLEAR;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_FOLD: begin
          fold_r  <= fold_sum;
          state_r <= ST_RECIP;
        end
        ST_RECIP: begin
          q_r     <= q_prod[63:32];
          state_r <= ST_REDUCE;
        end
        ST_REDUCE: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eval_done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == BW'(BUCKETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // memory is written only by the clearing pass or a finishing update
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_CLEAR || state_r == ST_EVAL))
    else $error("row write outside update or clear");

  // a result appears only from a finishing lookup
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EVAL && req_r.kind == KIND_LOOKUP))
    else $error("result word without lookup");

  // update is never entered without a row read
  a_read_before_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && !$past(state_r == ST_EVAL)) |-> $past(rd_en))
    else $error("update entered without row read");

endmodule

// File: src/sattt_update.sv
// bucket row update: key match, keep/overwrite, append and replacement choice
module sattt_update import sattt_pkg::*; #(
  parameter int WAYS = 8,
  localparam int FW  = $clog2(WAYS + 1),
  localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int RW  = FW + WAYS * ENTRY_W
) (
  input  req_t            req,
  input  logic [RW-1:0]   row_i,
  output logic [RW-1:0]   row_o,
  output upd_res_t        res
);

  logic [FW-1:0]      fill;
  logic [FW-1:0]      fill_n;
  logic [ENTRY_W-1:0] ent   [WAYS];
  logic [ENTRY_W-1:0] ent_n [WAYS];
  logic [INFO_W-1:0]  new_info;
  logic [INFO_W-1:0]  old;
  logic               hit;
  logic [WIW-1:0]     hidx;
  logic               p1_ok, p2_ok;
  logic [WIW-1:0]     p1, p2;
  logic               keep;

  always_comb begin
    fill     = row_i[FW-1:0];
    new_info = pack_info(req);
    for (int w = 0; w < WAYS; w++) begin
      ent[w] = row_i[FW + w*ENTRY_W +: ENTRY_W];
    end
    // first filled way holding the key
    hit  = 1'b0;
    hidx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((FW'(w) < fill) && (ent[w][INFO_W +: KEY_W] == req.key)) begin
        hit  = 1'b1;
        hidx = WIW'(w);
      end
    end
    old  = ent[hidx][INFO_W-1:0];
    keep = (old[LIMIT_LSB +: DEPTH_W] == req.limit) &&
           ((req.depth <= old[DEPTH_LSB +: DEPTH_W]) ||
            (old[BOUND_LSB +: BOUND_W] == BOUND_EXACT));
    // victim choice in a full bucket
    p1_ok = 1'b0;
    p1    = '0;
    p2_ok = 1'b0;
    p2    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ent[w][LIMIT_LSB +: DEPTH_W] != req.limit) begin
        p1_ok = 1'b1;
        p1    = WIW'(w);
      end
      if (ent[w][DEPTH_LSB +: DEPTH_W] > req.depth) begin
        p2_ok = 1'b1;
        p2    = WIW'(w);
      end
    end

    ent_n    = ent;
    fill_n   = fill;
    res.wr   = 1'b0;
    res.hit  = 1'b0;
    res.info = '0;
    case (req.kind)
      KIND_STORE: begin
        if (hit) begin
          if (!keep) begin
            ent_n[hidx][INFO_W-1:0] = new_info;
            res.wr = 1'b1;
          end
        end else if (fill < FW'(WAYS)) begin
          ent_n[fill[WIW-1:0]] = {req.key, new_info};
          fill_n = fill + FW'(1);
          res.wr = 1'b1;
        end else if (p1_ok || p2_ok) begin
          ent_n[p1_ok ? p1 : p2] = ent[WAYS-1];
          ent_n[WAYS-1]          = {req.key, new_info};
          res.wr = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        res.hit  = hit;
        res.info = hit ? old : '0;
      end
      default: begin
      end
    endcase

    row_o[FW-1:0] = fill_n;
    for (int w = 0; w < WAYS; w++) begin
      row_o[FW + w*ENTRY_W +: ENTRY_W] = ent_n[w];
    end
  end

endmodule
